>>> hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the character map of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int CFG_W           = 16;
  localparam int OUT_LEN_W       = 16;
  localparam int FIFO_DEPTH      = 4;

  localparam logic [CFG_W-1:0] MAX_OUT_RESET = 16'hFFFF;

  // Character classes.
  localparam logic [1:0] CLS_DATA = 2'd0;
  localparam logic [1:0] CLS_PAD  = 2'd1;
  localparam logic [1:0] CLS_BAD  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DATA    = 2'd0;
  localparam logic [1:0] ST_END_OK  = 2'd1;
  localparam logic [1:0] ST_END_ERR = 2'd2;

  typedef struct packed {
    logic [1:0] cls;
    logic [5:0] val;
  } sextet_t;

  // One queued job for the back end: the bytes of a finished group and/or
  // an end record.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        is_end;
    logic        err;
  } op_t;

  function automatic sextet_t map_char(input logic [7:0] c);
    sextet_t s;
    s.cls = CLS_BAD;
    s.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.cls = CLS_DATA;
      s.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.cls = CLS_DATA;
      s.val = 6'(c - 8'h47);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.cls = CLS_DATA;
      s.val = 6'(c + 8'h04);
    end else if (c == 8'h2B) begin
      s.cls = CLS_DATA;
      s.val = 6'd62;
    end else if (c == 8'h2F) begin
      s.cls = CLS_DATA;
      s.val = 6'd63;
    end else if (c == 8'h3D) begin
      s.cls = CLS_PAD;
    end
    return s;
  endfunction

endpackage

>>> hw/rtl/b64d_fifo.sv
// ----------------------------------------------------------------------------
// b64d_fifo
// Small register queue between the decoder front end and back end.
// ----------------------------------------------------------------------------
module b64d_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = b64d_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> hw/rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks the group and the byte count, and queues the
// bytes of each finished group together with any end record.
// ----------------------------------------------------------------------------
module b64d_front #(
  parameter int LENGTH_BITS = b64d_pkg::LENGTH_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [b64d_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                         in_push,
  input  logic [7:0]                   in_char_code,
  input  logic                         in_end_of_text,
  input  logic                         q_full,
  output logic                         q_push,
  output b64d_pkg::op_t                q_op,
  output logic [LENGTH_BITS-1:0]       q_len
);

  localparam int LW = (LENGTH_BITS > b64d_pkg::CFG_W) ? LENGTH_BITS : b64d_pkg::CFG_W;

  logic [b64d_pkg::CFG_W-1:0] max_r;
  logic [17:0]                grp_r, grp_nxt;
  logic [1:0]                 gp_r, gp_nxt;
  logic [1:0]                 pc_r, pc_nxt;
  logic [LENGTH_BITS-1:0]     bw_r, bw_nxt;
  logic                       err_r, err_nxt;

  b64d_pkg::sextet_t sx;
  logic              accept;
  logic              take;
  logic [1:0]        nbytes;
  logic [1:0]        nwrite;
  logic [1:0]        avail;
  logic [LW-1:0]     cap_w, max_w, limit_w;
  logic [LW:0]       diff;
  logic [23:0]       word;
  logic              err_end;

  assign accept = in_push && !q_full;
  assign sx     = b64d_pkg::map_char(in_char_code);
  assign word   = {grp_r, sx.val};

  // Room left under the byte limit, clamped to one group's worth.
  always_comb begin
    cap_w   = LW'({LENGTH_BITS{1'b1}});
    max_w   = LW'(max_r);
    limit_w = (max_w < cap_w) ? max_w : cap_w;
    diff    = {1'b0, limit_w} - {1'b0, LW'(bw_r)};
    if (diff[LW] || diff == '0) begin
      avail = 2'd0;
    end else if (diff >= (LW+1)'(3)) begin
      avail = 2'd3;
    end else begin
      avail = diff[1:0];
    end
  end

  always_comb begin
    grp_nxt = grp_r;
    gp_nxt  = gp_r;
    pc_nxt  = pc_r;
    bw_nxt  = bw_r;
    err_nxt = err_r;
    nbytes  = 2'd0;
    nwrite  = 2'd0;
    take    = 1'b0;
    if (sx.cls == b64d_pkg::CLS_BAD) begin
      err_nxt = 1'b1;
    end else if (gp_r == 2'd0 && pc_r != 2'd0) begin
      err_nxt = 1'b1;
    end else if (sx.cls == b64d_pkg::CLS_PAD && gp_r < 2'd2) begin
      err_nxt = 1'b1;
    end else if (sx.cls == b64d_pkg::CLS_DATA && pc_r != 2'd0) begin
      err_nxt = 1'b1;
    end else begin
      take = 1'b1;
    end

    if (take) begin
      if (sx.cls == b64d_pkg::CLS_PAD) begin
        pc_nxt = pc_r + 2'd1;
      end
      if (gp_r != 2'd3) begin
        grp_nxt = {grp_r[11:0], sx.val};
        gp_nxt  = gp_r + 2'd1;
      end else begin
        nbytes  = 2'd3 - ((pc_nxt > 2'd2) ? 2'd2 : pc_nxt);
        nwrite  = (nbytes < avail) ? nbytes : avail;
        bw_nxt  = bw_r + LENGTH_BITS'(nwrite);
        grp_nxt = '0;
        gp_nxt  = 2'd0;
      end
    end

    err_end = err_nxt || (gp_nxt != 2'd0);

    // The end record closes the text and returns the state to its start.
    if (in_end_of_text) begin
      grp_nxt = '0;
      gp_nxt  = 2'd0;
      pc_nxt  = 2'd0;
      bw_nxt  = '0;
      err_nxt = 1'b0;
    end
  end

  assign q_push      = accept && (in_end_of_text || nwrite != 2'd0);
  assign q_op.word   = word;
  assign q_op.nbytes = nwrite;
  assign q_op.is_end = in_end_of_text;
  assign q_op.err    = err_end;
  assign q_len       = bw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= b64d_pkg::MAX_OUT_RESET;
      grp_r <= '0;
      gp_r  <= '0;
      pc_r  <= '0;
      bw_r  <= '0;
      err_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      if (accept) begin
        grp_r <= grp_nxt;
        gp_r  <= gp_nxt;
        pc_r  <= pc_nxt;
        bw_r  <= bw_nxt;
        err_r <= err_nxt;
      end
    end
  end

endmodule

>>> hw/rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Unpacks queued jobs into single result beats held in an output register.
// ----------------------------------------------------------------------------
module b64d_back #(
  parameter int LENGTH_BITS = b64d_pkg::LENGTH_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  b64d_pkg::op_t                     q_op,
  input  logic [LENGTH_BITS-1:0]            q_len,
  output logic                              q_pop,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [7:0]                        out_data_byte,
  output logic [1:0]                        out_status,
  output logic [b64d_pkg::OUT_LEN_W-1:0]    out_decoded_length,
  output logic                              out_last
);

  localparam int LW = (LENGTH_BITS > b64d_pkg::OUT_LEN_W) ? LENGTH_BITS
                                                         : b64d_pkg::OUT_LEN_W;

  logic [1:0]                     idx_r, idx_nxt;
  logic                           ov_r, ov_nxt;
  logic [7:0]                     byte_r;
  logic [1:0]                     status_r;
  logic [b64d_pkg::OUT_LEN_W-1:0] len_r;
  logic                           last_r;

  logic                           load;
  logic                           is_byte;
  logic                           last_of_op;
  logic [7:0]                     sel_byte;
  logic [1:0]                     sel_status;
  logic [LENGTH_BITS-1:0]         sel_len;
  logic [LW-1:0]                  sel_len_w;

  assign load    = !q_empty && (!ov_r || out_pop);
  assign is_byte = (idx_r < q_op.nbytes);

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = q_op.word[23:16];
      2'd1:    sel_byte = q_op.word[15:8];
      default: sel_byte = q_op.word[7:0];
    endcase
    if (is_byte) begin
      last_of_op = (({1'b0, idx_r} + 3'd1) == {1'b0, q_op.nbytes}) && !q_op.is_end;
      sel_status = b64d_pkg::ST_DATA;
      sel_len    = q_len + LENGTH_BITS'(idx_r) + LENGTH_BITS'(1);
    end else begin
      last_of_op = 1'b1;
      sel_status = q_op.err ? b64d_pkg::ST_END_ERR : b64d_pkg::ST_END_OK;
      sel_len    = q_len + LENGTH_BITS'(q_op.nbytes);
      sel_byte   = 8'd0;
    end
    sel_len_w = LW'(sel_len);
  end

  assign q_pop = load && last_of_op;

  always_comb begin
    idx_nxt = idx_r;
    ov_nxt  = ov_r;
    if (load) begin
      idx_nxt = last_of_op ? 2'd0 : idx_r + 2'd1;
      ov_nxt  = 1'b1;
    end else if (out_pop) begin
      ov_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= sel_byte;
      status_r <= sel_status;
      len_r    <= sel_len_w[b64d_pkg::OUT_LEN_W-1:0];
      last_r   <= !is_byte;
    end
  end

  assign out_empty          = !ov_r;
  assign out_data_byte      = byte_r;
  assign out_status         = status_r;
  assign out_decoded_length = len_r;
  assign out_last           = last_r;

endmodule

>>> hw/rtl/base64_decoder_core.sv
// ----------------------------------------------------------------------------
// base64_decoder_core
// Base64 text decoder: one character per beat in, bytes and an end record out.
// ----------------------------------------------------------------------------
// The first result of a character passes through the queue and then the output
// register before it reaches the outputs.
// Throughput: one character per cycle while the queue is not full; the output
// register delivers one result per cycle while the consumer pops each one.
// Reset: synchronous, active low; clears the decoder state and the queue and
// sets the byte limit to 65535.
module base64_decoder_core #(
  parameter int LENGTH_BITS = b64d_pkg::LENGTH_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [b64d_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [7:0]                        in_char_code,
  input  logic                              in_end_of_text,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [7:0]                        out_data_byte,
  output logic [1:0]                        out_status,
  output logic [b64d_pkg::OUT_LEN_W-1:0]    out_decoded_length,
  output logic                              out_last
);

  localparam int OPW = $bits(b64d_pkg::op_t);
  localparam int QW  = OPW + LENGTH_BITS;

  logic                   q_push, q_pop, q_full, q_empty;
  b64d_pkg::op_t          f_op, b_op;
  logic [LENGTH_BITS-1:0] f_len, b_len;
  logic [QW-1:0]          q_rdata;

  assign in_full = q_full;

  b64d_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_op           (f_op),
    .q_len          (f_len)
  );

  b64d_fifo #(
    .WIDTH(QW),
    .DEPTH(b64d_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_op, f_len}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign b_op  = q_rdata[QW-1:LENGTH_BITS];
  assign b_len = q_rdata[LENGTH_BITS-1:0];

  b64d_back #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_op               (b_op),
    .q_len              (b_len),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_data_byte      (out_data_byte),
    .out_status         (out_status),
    .out_decoded_length (out_decoded_length),
    .out_last           (out_last)
  );

endmodule
